### rtl/wrsl_pkg.sv
// shared constants, types and state codes for the weighted rms sound level meter
package wrsl_pkg;

    // delay line geometry (depth is a power of two: slot wrap and the final divide use it)
    localparam int DEPTH       = 1024;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int SAMPLE_BITS = 10;

    // offset register
    localparam int OFFSET_W = 10;
    localparam logic [OFFSET_W-1:0] OFFSET_RESET = 10'd780;
    localparam logic [SAMPLE_BITS-1:0] RESET_SAMPLE = SAMPLE_BITS'(OFFSET_RESET);

    // datapath widths
    localparam int DEV_W    = (SAMPLE_BITS > OFFSET_W) ? SAMPLE_BITS : OFFSET_W;
    localparam int SQ_W     = 2 * DEV_W;
    localparam int WEIGHT_W = ADDR_W + 1;
    localparam int PROD_W   = SQ_W + WEIGHT_W;
    localparam int ACC_W    = SQ_W + 2 * ADDR_W;
    localparam int RAD_W    = ((ACC_W - ADDR_W + 1) / 2) * 2;
    localparam int ROOT_W   = RAD_W / 2;
    localparam int REM_W    = ROOT_W + 2;
    localparam int STEP_W   = $clog2(ROOT_W);

    // stream widths
    localparam int LEVEL_W     = 15;
    localparam int IN_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((LEVEL_W + 7) / 8) * 8;

    // request kinds carried in tuser
    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_ROOT,
        S_HOLD
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic              push;
        logic              clear_acc;
        logic              issue;
        logic [ADDR_W-1:0] idx;
        logic              root_load;
        logic              root_step;
        logic              out_load;
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic pipe_busy;
    } t_dp_sts;

endpackage

### rtl/weighted_rms_sound_level.sv
// top level of the weighted rms sound level meter
// push request: written straight into the line, next request accepted in the following cycle
// level request: one delay line read and one multiply-accumulate per delay line slot,
//   then one root bit a cycle
// the level stays in an output register so pushes continue while it waits to be taken
// synchronous active low reset; the line reads as the offset reset value until written
module weighted_rms_sound_level (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [wrsl_pkg::OFFSET_W-1:0]    i_cfg_wdata,    // dc_offset
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [wrsl_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // [9:0] sample, rest zero
    input  logic [0:0]                       s_axis_tuser,   // [0] op
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [wrsl_pkg::OUT_TDATA_W-1:0] m_axis_tdata    // [14:0] level, rest zero
);

    wrsl_pkg::t_dp_cmd             dp_cmd;
    wrsl_pkg::t_dp_sts             dp_sts;
    logic [wrsl_pkg::LEVEL_W-1:0]  level;

    // control
    wrsl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_op     (s_axis_tuser[0]),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    // datapath
    wrsl_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .i_sample    (s_axis_tdata[wrsl_pkg::SAMPLE_BITS-1:0]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_sts       (dp_sts),
        .o_level     (level)
    );

    assign m_axis_tdata = {{(wrsl_pkg::OUT_TDATA_W - wrsl_pkg::LEVEL_W){1'b0}}, level};

endmodule

### rtl/wrsl_ram.sv
// generic simple dual port ram with registered read
module wrsl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/wrsl_datapath.sv
// datapath: sample line, weighted square accumulator, bit-pair square root, result register
module wrsl_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  wrsl_pkg::t_dp_cmd                i_cmd,
    input  logic [wrsl_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic                             i_cfg_we,
    input  logic [wrsl_pkg::OFFSET_W-1:0]    i_cfg_wdata,
    output wrsl_pkg::t_dp_sts                o_sts,
    output logic [wrsl_pkg::LEVEL_W-1:0]     o_level
);

    // configuration and line bookkeeping
    logic [wrsl_pkg::OFFSET_W-1:0]    r_dc_offset;
    logic [wrsl_pkg::ADDR_W-1:0]      r_newest;
    logic [wrsl_pkg::WEIGHT_W-1:0]    r_fill;

    // scan pipeline
    logic                             r_v1, r_v2, r_v3, r_v4;
    logic                             r_wr1;
    logic [wrsl_pkg::WEIGHT_W-1:0]    r_w1, r_w2, r_w3;
    logic [wrsl_pkg::DEV_W-1:0]       r_dev;
    logic [wrsl_pkg::SQ_W-1:0]        r_sq;
    logic [wrsl_pkg::PROD_W-1:0]      r_prod;
    logic [wrsl_pkg::ACC_W-1:0]       r_acc;

    // square root unit
    logic [wrsl_pkg::RAD_W-1:0]       r_rad;
    logic [wrsl_pkg::REM_W-1:0]       r_rem;
    logic [wrsl_pkg::ROOT_W-1:0]      r_root;
    logic [wrsl_pkg::LEVEL_W-1:0]     r_level;

    logic [wrsl_pkg::ADDR_W-1:0]      ram_waddr;
    logic [wrsl_pkg::ADDR_W-1:0]      ram_raddr;
    logic [wrsl_pkg::SAMPLE_BITS-1:0] ram_rdata;
    logic [wrsl_pkg::SAMPLE_BITS-1:0] cur_sample;
    logic [wrsl_pkg::DEV_W-1:0]       cur_s, cur_off, n_dev;
    logic [wrsl_pkg::SQ_W-1:0]        n_sq;
    logic [wrsl_pkg::PROD_W-1:0]      n_prod;
    logic [wrsl_pkg::REM_W+1:0]       rem_sh, trial, diff;
    logic                             root_ge;

    // delay line storage
    assign ram_waddr = r_newest + 1'b1;
    assign ram_raddr = r_newest - i_cmd.idx;

    wrsl_ram #(
        .WIDTH (wrsl_pkg::SAMPLE_BITS),
        .DEPTH (wrsl_pkg::DEPTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_waddr (ram_waddr),
        .i_wdata (i_sample),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // offset register, newest slot and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dc_offset <= wrsl_pkg::OFFSET_RESET;
            r_newest    <= '0;
            r_fill      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_dc_offset <= i_cfg_wdata;
            end
            if (i_cmd.push) begin
                r_newest <= ram_waddr;
                if (r_fill != wrsl_pkg::WEIGHT_W'(wrsl_pkg::DEPTH)) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
        end
    end

    // never written slots read as the reset sample
    assign cur_sample = r_wr1 ? ram_rdata : wrsl_pkg::RESET_SAMPLE;
    assign cur_s      = wrsl_pkg::DEV_W'(cur_sample);
    assign cur_off    = wrsl_pkg::DEV_W'(r_dc_offset);
    assign n_dev      = (cur_s >= cur_off) ? (cur_s - cur_off) : (cur_off - cur_s);
    assign n_sq       = r_dev * r_dev;
    assign n_prod     = r_sq * r_w3;

    // pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // pipeline payload: weight and written flag, deviation, square, weighted square
    always_ff @(posedge i_clk) begin
        r_w1   <= wrsl_pkg::WEIGHT_W'(wrsl_pkg::DEPTH) - {1'b0, i_cmd.idx};
        r_wr1  <= ({1'b0, i_cmd.idx} < r_fill);
        r_dev  <= n_dev;
        r_w2   <= r_w1;
        r_sq   <= n_sq;
        r_w3   <= r_w2;
        r_prod <= n_prod;
    end

    // accumulator
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_acc) begin
            r_acc <= '0;
        end else if (r_v4) begin
            r_acc <= r_acc + {{(wrsl_pkg::ACC_W - wrsl_pkg::PROD_W){1'b0}}, r_prod};
        end
    end

    // one root bit per step, two radicand bits shifted in
    assign rem_sh  = {r_rem, r_rad[wrsl_pkg::RAD_W-1 -: 2]};
    assign trial   = {2'b00, r_root, 2'b01};
    assign diff    = rem_sh - trial;
    assign root_ge = (rem_sh >= trial);

    always_ff @(posedge i_clk) begin
        if (i_cmd.root_load) begin
            r_rad  <= wrsl_pkg::RAD_W'(r_acc[wrsl_pkg::ACC_W-1:wrsl_pkg::ADDR_W]);
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_cmd.root_step) begin
            r_rad  <= {r_rad[wrsl_pkg::RAD_W-3:0], 2'b00};
            r_rem  <= root_ge ? diff[wrsl_pkg::REM_W-1:0] : rem_sh[wrsl_pkg::REM_W-1:0];
            r_root <= {r_root[wrsl_pkg::ROOT_W-2:0], root_ge};
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_level <= wrsl_pkg::LEVEL_W'(r_root);
        end
    end

    assign o_sts.pipe_busy = r_v1 | r_v2 | r_v3 | r_v4;
    assign o_level         = r_level;

endmodule

### rtl/wrsl_ctrl.sv
// controller: request decode, scan sequencing, root steps and output handshake
module wrsl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_op,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  wrsl_pkg::t_dp_sts i_sts,
    output wrsl_pkg::t_dp_cmd o_cmd
);

    wrsl_pkg::t_state                r_state, n_state;
    logic [wrsl_pkg::ADDR_W-1:0]     r_idx, n_idx;
    logic [wrsl_pkg::STEP_W-1:0]     r_step, n_step;
    logic                            r_out_valid, n_out_valid;

    // state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wrsl_pkg::S_IDLE;
            r_idx       <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and commands
    always_comb begin
        n_state        = r_state;
        n_idx          = r_idx;
        n_step         = r_step;
        o_in_ready     = 1'b0;
        o_cmd          = '0;
        o_cmd.idx      = r_idx;
        n_out_valid    = r_out_valid && !i_out_ready;

        case (r_state)
            wrsl_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_op == wrsl_pkg::OP_QUERY) begin
                        o_cmd.clear_acc = 1'b1;
                        n_idx           = '0;
                        n_state         = wrsl_pkg::S_SCAN;
                    end else begin
                        o_cmd.push = 1'b1;
                    end
                end
            end
            wrsl_pkg::S_SCAN: begin
                o_cmd.issue = 1'b1;
                n_idx       = r_idx + 1'b1;
                if (r_idx == wrsl_pkg::ADDR_W'(wrsl_pkg::DEPTH - 1)) begin
                    n_state = wrsl_pkg::S_DRAIN;
                end
            end
            wrsl_pkg::S_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    o_cmd.root_load = 1'b1;
                    n_step          = '0;
                    n_state         = wrsl_pkg::S_ROOT;
                end
            end
            wrsl_pkg::S_ROOT: begin
                o_cmd.root_step = 1'b1;
                n_step          = r_step + 1'b1;
                if (r_step == wrsl_pkg::STEP_W'(wrsl_pkg::ROOT_W - 1)) begin
                    n_state = wrsl_pkg::S_HOLD;
                end
            end
            wrsl_pkg::S_HOLD: begin
                // wait for the result register to be free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = wrsl_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = wrsl_pkg::S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

### rtl/wrsl_checker.sv
// port level checks for the weighted rms sound level meter, bound to the top level
module wrsl_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [0:0]                       s_axis_tuser,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [wrsl_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // a level request makes the block busy in the next cycle
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == wrsl_pkg::OP_QUERY)
        |=> !s_axis_tready)
        else $error("level request did not start a scan");

    // a push request leaves the block ready
    a_push_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == wrsl_pkg::OP_PUSH)
        |=> s_axis_tready)
        else $error("push request blocked the input");

    // a new result only appears at the end of a busy spell
    a_result_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without a level request");

    // upper result bits stay zero
    a_level_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[wrsl_pkg::OUT_TDATA_W-1:wrsl_pkg::LEVEL_W] == '0))
        else $error("result padding not zero");

endmodule

bind weighted_rms_sound_level wrsl_checker u_wrsl_checker (.*);
